@@ rtl/core/qte_pkg.sv @@
// Shared types and constants for the quaternion to Euler angles pipeline.
`default_nettype none
package qte_pkg;

  localparam int unsigned OPW      = 34;  // atan2 operand width after the front end
  localparam int unsigned SQA_W    = 33;  // clamped square-root argument
  localparam int unsigned SQ_RAD_W = 54;  // argument shifted left 20, padded to even
  localparam int unsigned SQ_STEPS = SQ_RAD_W / 2;
  localparam int unsigned SQ_ROOT_W = SQ_STEPS;
  localparam int unsigned SQ_REM_W = SQ_ROOT_W + 2;
  localparam int unsigned CW       = 38;  // CORDIC x/y width
  localparam int unsigned AW       = 30;  // angle accumulator, degrees * 2^20
  localparam int unsigned ANG_LEN  = 24;

  localparam logic signed [AW-1:0] DEG90 = 30'sd94371840;
  localparam logic signed [OPW-1:0] ONE_Q28 = 34'sd268435456;

  localparam logic signed [AW-1:0] ANG [ANG_LEN] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
    30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
    30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
    30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
    30'sd917,      30'sd458,      30'sd229,      30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7
  };

  typedef struct packed {
    logic signed [OPW-1:0] num_r;
    logic signed [OPW-1:0] den_r;
    logic signed [OPW-1:0] num_y;
    logic signed [OPW-1:0] den_y;
  } rpy_ops_t;

  typedef struct packed {
    rpy_ops_t           ops;
    logic [SQA_W-1:0]   arg_a;
    logic [SQA_W-1:0]   arg_b;
  } front_t;

  typedef struct packed {
    logic [SQ_RAD_W-1:0]  rad;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_REM_W-1:0]  rem;
  } sq_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } cordic_t;

endpackage
`default_nettype wire

@@ rtl/core/qte_in_if.sv @@
// Input channel: one quaternion per transaction.
`default_nettype none
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

@@ rtl/core/qte_out_if.sv @@
// Output channel: roll, pitch and yaw per transaction.
`default_nettype none
interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [14:0] pitch_deg;
  logic signed [15:0] yaw_deg;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface
`default_nettype wire

@@ rtl/core/qte_front.sv @@
// Front end: component products, then atan2 operands and clamped root arguments.
`default_nettype none
module qte_front (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  input  wire logic signed [15:0] z_i,
  input  wire logic signed [15:0] w_i,
  output qte_pkg::front_t         front_o
);

  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, xz_q;
  qte_pkg::front_t    front_q, front_d;

  logic signed [32:0] s_roll_n, s_roll_d, s_yaw_n, s_yaw_d, s_t;
  logic signed [34:0] a_full, b_full;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q <= 32'(w_i) * 32'(x_i);
      yz_q <= 32'(y_i) * 32'(z_i);
      xx_q <= 32'(x_i) * 32'(x_i);
      yy_q <= 32'(y_i) * 32'(y_i);
      wz_q <= 32'(w_i) * 32'(z_i);
      xy_q <= 32'(x_i) * 32'(y_i);
      zz_q <= 32'(z_i) * 32'(z_i);
      wy_q <= 32'(w_i) * 32'(y_i);
      xz_q <= 32'(x_i) * 32'(z_i);
    end
  end

  always_comb begin
    s_roll_n = 33'(wx_q) + 33'(yz_q);
    s_roll_d = 33'(xx_q) + 33'(yy_q);
    s_yaw_n  = 33'(wz_q) + 33'(xy_q);
    s_yaw_d  = 33'(yy_q) + 33'(zz_q);
    s_t      = 33'(wy_q) - 33'(xz_q);
    front_d.ops.num_r = {s_roll_n, 1'b0};
    front_d.ops.den_r = qte_pkg::ONE_Q28 - {s_roll_d, 1'b0};
    front_d.ops.num_y = {s_yaw_n, 1'b0};
    front_d.ops.den_y = qte_pkg::ONE_Q28 - {s_yaw_d, 1'b0};
    a_full = 35'(qte_pkg::ONE_Q28) + {s_t[32], s_t, 1'b0};
    b_full = 35'(qte_pkg::ONE_Q28) - {s_t[32], s_t, 1'b0};
    front_d.arg_a = a_full[34] ? '0 : a_full[qte_pkg::SQA_W-1:0];
    front_d.arg_b = b_full[34] ? '0 : b_full[qte_pkg::SQA_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule
`default_nettype wire

@@ rtl/core/qte_sqrt_step.sv @@
// One registered digit of the restoring integer square root.
`default_nettype none
module qte_sqrt_step (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  qte_pkg::sq_t     sq_i,
  output qte_pkg::sq_t     sq_o
);

  logic [qte_pkg::SQ_REM_W+1:0] trial_rem;
  logic [qte_pkg::SQ_REM_W+1:0] trial_sub;
  logic                         ge;
  qte_pkg::sq_t                 sq_d, sq_q;

  always_comb begin
    trial_rem = {sq_i.rem, sq_i.rad[qte_pkg::SQ_RAD_W-1 -: 2]};
    trial_sub = {2'b00, sq_i.root, 2'b01};
    ge        = trial_rem >= trial_sub;
    sq_d.rad  = {sq_i.rad[qte_pkg::SQ_RAD_W-3:0], 2'b00};
    sq_d.root = {sq_i.root[qte_pkg::SQ_ROOT_W-2:0], ge};
    sq_d.rem  = ge ? qte_pkg::SQ_REM_W'(trial_rem - trial_sub)
                   : trial_rem[qte_pkg::SQ_REM_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule
`default_nettype wire

@@ rtl/core/qte_cordic_pre.sv @@
// Quadrant fold into the right half-plane before the CORDIC iterations.
`default_nettype none
module qte_cordic_pre (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic signed [qte_pkg::CW-1:0] x_i,
  input  wire logic signed [qte_pkg::CW-1:0] y_i,
  output qte_pkg::cordic_t               cr_o
);

  qte_pkg::cordic_t cr_d, cr_q;

  always_comb begin
    cr_d.zero = (x_i == '0) && (y_i == '0);
    cr_d.x    = x_i;
    cr_d.y    = y_i;
    cr_d.acc  = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        cr_d.x   = y_i;
        cr_d.y   = -x_i;
        cr_d.acc = qte_pkg::DEG90;
      end else begin
        cr_d.x   = -y_i;
        cr_d.y   = x_i;
        cr_d.acc = -qte_pkg::DEG90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q <= cr_d;
    end
  end

  assign cr_o = cr_q;

endmodule
`default_nettype wire

@@ rtl/core/qte_cordic_step.sv @@
// One registered vectoring-mode CORDIC iteration.
`default_nettype none
module qte_cordic_step #(
  parameter int unsigned SHIFT = 0
) (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  qte_pkg::cordic_t cr_i,
  output qte_pkg::cordic_t cr_o
);

  logic signed [qte_pkg::CW-1:0] x, y, xs, ys;
  qte_pkg::cordic_t              cr_d, cr_q;

  always_comb begin
    x  = cr_i.x;
    y  = cr_i.y;
    xs = x >>> SHIFT;
    ys = y >>> SHIFT;
    cr_d.zero = cr_i.zero;
    if (y >= 0) begin
      cr_d.x   = x + ys;
      cr_d.y   = y - xs;
      cr_d.acc = cr_i.acc + qte_pkg::ANG[SHIFT];
    end else begin
      cr_d.x   = x - ys;
      cr_d.y   = y + xs;
      cr_d.acc = cr_i.acc - qte_pkg::ANG[SHIFT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_q <= cr_d;
    end
  end

  assign cr_o = cr_q;

endmodule
`default_nettype wire

@@ rtl/core/quaternion_to_euler_angles.sv @@
// Top level: quaternion to roll, pitch and yaw, fully pipelined.
// A new quaternion is taken every cycle while the output is free or being taken; the
// pipeline has two front-end stages (products, sums), 27 square-root digit stages for the
// pitch operands, one quadrant fold, one stage per CORDIC iteration and the output register.
// The whole pipeline freezes while a result waits, so throughput is one transaction per
// cycle while no result waits, and a stall loses nothing. No state is kept between items.
`default_nettype none
module quaternion_to_euler_angles #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qte_in_if.sink     in_i,
  qte_out_if.source  out_o
);

  localparam int unsigned LAT = 2 + qte_pkg::SQ_STEPS + 1 + CORDIC_STEPS + 1;

  logic            en;
  logic [LAT-1:0]  vld_q;

  qte_pkg::front_t   front;
  qte_pkg::sq_t      sq_a [qte_pkg::SQ_STEPS+1];
  qte_pkg::sq_t      sq_b [qte_pkg::SQ_STEPS+1];
  qte_pkg::rpy_ops_t ops_q [qte_pkg::SQ_STEPS];
  qte_pkg::cordic_t  cr_r [CORDIC_STEPS+1];
  qte_pkg::cordic_t  cr_p [CORDIC_STEPS+1];
  qte_pkg::cordic_t  cr_y [CORDIC_STEPS+1];

  logic signed [15:0] roll_q, yaw_q, roll_d, yaw_d;
  logic signed [14:0] pitch_q, pitch_d;
  logic signed [qte_pkg::AW-1:0] acc_r, acc_p, acc_y;
  logic signed [31:0] pitch_acc;

  function automatic logic signed [18:0] round_sat(input logic signed [31:0] v,
                                                   input logic signed [18:0] lim);
    logic signed [31:0] s;
    logic signed [18:0] r;
    s = (v + 32'sd4096) >>> 13;
    r = s[18:0];
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  assign en          = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  qte_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (in_i.quat_x),
    .y_i     (in_i.quat_y),
    .z_i     (in_i.quat_z),
    .w_i     (in_i.quat_w),
    .front_o (front)
  );

  assign sq_a[0] = '{rad: {1'b0, front.arg_a, 20'b0}, root: '0, rem: '0};
  assign sq_b[0] = '{rad: {1'b0, front.arg_b, 20'b0}, root: '0, rem: '0};

  for (genvar k = 0; k < qte_pkg::SQ_STEPS; k++) begin : g_sqrt
    qte_sqrt_step u_sq_a (.clk_i(clk_i), .en_i(en), .sq_i(sq_a[k]), .sq_o(sq_a[k+1]));
    qte_sqrt_step u_sq_b (.clk_i(clk_i), .en_i(en), .sq_i(sq_b[k]), .sq_o(sq_b[k+1]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        ops_q[k] <= (k == 0) ? front.ops : ops_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  qte_cordic_pre u_pre_r (
    .clk_i (clk_i), .en_i (en),
    .x_i   ({{4{ops_q[qte_pkg::SQ_STEPS-1].den_r[qte_pkg::OPW-1]}},
             ops_q[qte_pkg::SQ_STEPS-1].den_r}),
    .y_i   ({{4{ops_q[qte_pkg::SQ_STEPS-1].num_r[qte_pkg::OPW-1]}},
             ops_q[qte_pkg::SQ_STEPS-1].num_r}),
    .cr_o  (cr_r[0])
  );

  qte_cordic_pre u_pre_p (
    .clk_i (clk_i), .en_i (en),
    .x_i   ({11'b0, sq_b[qte_pkg::SQ_STEPS].root}),
    .y_i   ({11'b0, sq_a[qte_pkg::SQ_STEPS].root}),
    .cr_o  (cr_p[0])
  );

  qte_cordic_pre u_pre_y (
    .clk_i (clk_i), .en_i (en),
    .x_i   ({{4{ops_q[qte_pkg::SQ_STEPS-1].den_y[qte_pkg::OPW-1]}},
             ops_q[qte_pkg::SQ_STEPS-1].den_y}),
    .y_i   ({{4{ops_q[qte_pkg::SQ_STEPS-1].num_y[qte_pkg::OPW-1]}},
             ops_q[qte_pkg::SQ_STEPS-1].num_y}),
    .cr_o  (cr_y[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qte_cordic_step #(.SHIFT(i)) u_cr_r (
      .clk_i(clk_i), .en_i(en), .cr_i(cr_r[i]), .cr_o(cr_r[i+1]));
    qte_cordic_step #(.SHIFT(i)) u_cr_p (
      .clk_i(clk_i), .en_i(en), .cr_i(cr_p[i]), .cr_o(cr_p[i+1]));
    qte_cordic_step #(.SHIFT(i)) u_cr_y (
      .clk_i(clk_i), .en_i(en), .cr_i(cr_y[i]), .cr_o(cr_y[i+1]));
  end

  always_comb begin
    acc_r = cr_r[CORDIC_STEPS].zero ? '0 : cr_r[CORDIC_STEPS].acc;
    acc_p = cr_p[CORDIC_STEPS].zero ? '0 : cr_p[CORDIC_STEPS].acc;
    acc_y = cr_y[CORDIC_STEPS].zero ? '0 : cr_y[CORDIC_STEPS].acc;
    pitch_acc = {{1{acc_p[qte_pkg::AW-1]}}, acc_p, 1'b0} - 32'(qte_pkg::DEG90);
    roll_d  = 16'(round_sat(32'(acc_r), 19'sd23040));
    pitch_d = 15'(round_sat(pitch_acc, 19'sd11520));
    yaw_d   = 16'(round_sat(32'(acc_y), 19'sd23040));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_d;
      pitch_q <= pitch_d;
      yaw_q   <= yaw_d;
    end
  end

  assign out_o.roll_deg  = roll_q;
  assign out_o.pitch_deg = pitch_q;
  assign out_o.yaw_deg   = yaw_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (pitch_q <= 15'sd11520 && pitch_q >= -15'sd11520))
    else $error("pitch out of range");

  a_roll_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (roll_q <= 16'sd23040 && roll_q >= -16'sd23040 &&
                     yaw_q <= 16'sd23040 && yaw_q >= -16'sd23040))
    else $error("roll or yaw out of range");

endmodule
`default_nettype wire
